/* rtl/pfa_pkg.sv */
`default_nettype none

package pfa_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_OOM        = 3'd1;
  localparam logic [2:0] ST_MISALIGNED = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_UNINIT     = 3'd4;

  // Request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_REGION_START = 1'b0;
  localparam logic CFG_REGION_END   = 1'b1;

endpackage

`default_nettype wire

/* rtl/page_frame_allocator_unit.sv */
// Page frame allocator. Each request on the input channel (in_valid / in_stall)
// either allocates one frame (mode 0) or frees frame_address (mode 1). Exactly
// one result leaves on the output channel (out_valid / out_stall) per request:
// the granted address, a status code and the free bytes left afterwards.
// Allocation pops the most recently freed frame from the free stack, which is
// held in a synchronous memory; when the stack is empty the next fresh frame
// comes from a bump pointer between region_start and region_end.
// Requests are handled one at a time: an input transfer runs through memory
// read, bump address, decision, untouched bytes and final sum, one step per
// clock edge starting at the transfer edge while the final step need not wait,
// and the final sum loads the output register before a new request is taken.
// The output register holds a finished result while the receiver
// stalls; the next request is accepted meanwhile and waits at its last step
// only if the register is still full.
// The region registers are written through cfg_write / cfg_index / cfg_data;
// the user must write them only while the block is idle, which the block does
// not enforce. Reset clears the registers, the bump offset and the stack count;
// the stack memory is never cleared, as only entries below the count are used.
`default_nettype none

module page_frame_allocator_unit #(
  parameter int PAGE_BYTES   = 4096,
  parameter int STACK_DEPTH  = 1024,
  parameter int ADDRESS_BITS = 40
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // Configuration port
  input  wire logic                    cfg_write,
  input  wire logic                    cfg_index,
  input  wire logic [ADDRESS_BITS-1:0] cfg_data,
  // Request channel
  input  wire logic                    in_valid,
  output      logic                    in_stall,
  input  wire logic                    mode,
  input  wire logic [ADDRESS_BITS-1:0] frame_address,
  // Result channel
  output      logic                    out_valid,
  input  wire logic                    out_stall,
  output      logic [ADDRESS_BITS-1:0] granted_address,
  output      logic [2:0]              status,
  output      logic [ADDRESS_BITS:0]   free_bytes
);

  import pfa_pkg::*;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int FRAME_W    = ADDRESS_BITS - PAGE_SHIFT;
  localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W      = $clog2(STACK_DEPTH);
  localparam int BUMP_W     = ADDRESS_BITS + 2;
  localparam int STK_BYTE_W = CNT_W + PAGE_SHIFT;
  localparam int SUM_W      = ((ADDRESS_BITS > STK_BYTE_W) ? ADDRESS_BITS : STK_BYTE_W) + 2;

  localparam logic [CNT_W-1:0]        DEPTH_CNT = CNT_W'(STACK_DEPTH);
  localparam logic [ADDRESS_BITS:0]   BYTES_MAX = '1;
  localparam logic [BUMP_W-1:0]       PAGE_INC  = BUMP_W'(PAGE_BYTES);
  localparam logic [PAGE_SHIFT-1:0]   PAGE_ZERO = '0;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_UNT  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;

  logic [2:0]              state;
  logic [ADDRESS_BITS-1:0] region_start;
  logic [ADDRESS_BITS-1:0] region_end;
  logic [FRAME_W-1:0]      fresh_offset;
  logic [CNT_W-1:0]        stack_count;

  logic [FRAME_W-1:0]      free_stack [STACK_DEPTH];
  logic [FRAME_W-1:0]      stack_rdata;

  logic                    req_mode;
  logic [ADDRESS_BITS-1:0] req_frame;
  logic [BUMP_W-1:0]       bump_addr;
  logic [ADDRESS_BITS-1:0] untouched;
  logic [ADDRESS_BITS-1:0] res_granted;
  logic [2:0]              res_status;

  logic                    in_fire;
  logic                    out_free;
  logic [BUMP_W-1:0]       bump_end;
  logic                    bump_oom;
  logic [BUMP_W-1:0]       region_end_w;
  logic [SUM_W-1:0]        total;
  logic [IDX_W-1:0]        pop_idx;
  logic [IDX_W-1:0]        push_idx;
  logic                    push_en;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign pop_idx  = IDX_W'(stack_count - CNT_W'(1));
  assign push_idx = stack_count[IDX_W-1:0];

  // Bump check: does a whole page still fit below the region end?
  assign region_end_w = BUMP_W'(region_end);
  assign bump_end     = bump_addr + PAGE_INC;
  assign bump_oom     = bump_end > region_end_w;

  // A free that passes both checks writes the stack.
  assign push_en = (state == S_EXEC) && (req_mode == MODE_FREE) &&
                   (req_frame[PAGE_SHIFT-1:0] == PAGE_ZERO) && (stack_count < DEPTH_CNT);

  // Untouched bytes plus the bytes held on the stack.
  assign total = SUM_W'(untouched) + SUM_W'({stack_count, PAGE_ZERO});

  // Free stack memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (push_en) begin
      free_stack[push_idx] <= req_frame[ADDRESS_BITS-1:PAGE_SHIFT];
    end
    if (in_fire) begin
      stack_rdata <= free_stack[pop_idx];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_end   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_REGION_START: region_start <= cfg_data;
        CFG_REGION_END:   region_end   <= cfg_data;
        default:          region_start <= region_start;
      endcase
    end
  end

  // Request sequencer and allocator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fresh_offset <= '0;
      stack_count  <= '0;
      out_valid    <= 1'b0;
    end else begin
      // A taken result empties the register unless the final step refills it.
      if (out_valid && !out_stall && state != S_SUM) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (req_mode == MODE_ALLOC) begin
            if (region_start != '0) begin
              if (stack_count != '0) begin
                stack_count <= stack_count - CNT_W'(1);
              end else if (!bump_oom) begin
                fresh_offset <= fresh_offset + FRAME_W'(1);
              end
            end
          end else if (push_en) begin
            stack_count <= stack_count + CNT_W'(1);
          end
          state <= S_UNT;
        end
        S_UNT: begin
          state <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_mode  <= mode;
      req_frame <= frame_address;
    end

    // Bump address from the offset before this request.
    if (state == S_ADDR) begin
      bump_addr <= BUMP_W'(region_start) + BUMP_W'({fresh_offset, PAGE_ZERO});
    end

    // Decide the request; the bump address moves on by a page when taken.
    if (state == S_EXEC) begin
      if (req_mode == MODE_ALLOC) begin
        if (region_start == '0) begin
          res_granted <= '0;
          res_status  <= ST_UNINIT;
        end else if (stack_count != '0) begin
          res_granted <= {stack_rdata, PAGE_ZERO};
          res_status  <= ST_OK;
        end else if (bump_oom) begin
          res_granted <= '0;
          res_status  <= ST_OOM;
        end else begin
          res_granted <= bump_addr[ADDRESS_BITS-1:0];
          res_status  <= ST_OK;
          bump_addr   <= bump_end;
        end
      end else begin
        res_granted <= '0;
        if (req_frame[PAGE_SHIFT-1:0] != PAGE_ZERO) begin
          res_status <= ST_MISALIGNED;
        end else if (stack_count >= DEPTH_CNT) begin
          res_status <= ST_FULL;
        end else begin
          res_status <= ST_OK;
        end
      end
    end

    // Untouched part of the region, zero once the bump passes the end.
    if (state == S_UNT) begin
      if (region_end_w > bump_addr) begin
        untouched <= ADDRESS_BITS'(region_end_w - bump_addr);
      end else begin
        untouched <= '0;
      end
    end

    // Load the output register.
    if (state == S_SUM && out_free) begin
      granted_address <= res_granted;
      status          <= res_status;
      if (region_start == '0) begin
        free_bytes <= '0;
      end else if (total > SUM_W'(BYTES_MAX)) begin
        free_bytes <= BYTES_MAX;
      end else begin
        free_bytes <= total[ADDRESS_BITS:0];
      end
    end
  end

`ifndef SYNTHESIS
  // The stack count never runs past the memory depth.
  assert property (@(posedge clk) disable iff (rst) stack_count <= DEPTH_CNT)
    else $error("stack count beyond stack depth");

  // A new result only appears from the last step of the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_SUM)
    else $error("result raised outside the final step");

  // An address is only granted with a good status.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || granted_address == '0))
    else $error("address granted on a failed request");
`endif

endmodule

`default_nettype wire

/* verif/tb_page_frame_allocator_unit.sv */
`default_nettype none

module tb_page_frame_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pfa_pkg::*;

  localparam int ADDR_W = 40;
  localparam int PAGE_SHIFT = 12;
  localparam int STACK_DEPTH = 1024;
  localparam longint unsigned PAGE_BYTES = 64'd4096;
  localparam longint unsigned ADDR_MAX = (64'd1 << ADDR_W) - 1;
  localparam longint unsigned BYTES_MAX = (64'd1 << (ADDR_W + 1)) - 1;
  localparam int MAX_GAP = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PRINT_LIMIT = 40;

  typedef struct {
    logic              mode;
    logic [ADDR_W-1:0] addr;
  } frame_request_t;

  typedef struct {
    logic [ADDR_W-1:0] granted;
    logic [2:0]        status;
    logic [ADDR_W:0]   bytes;
  } frame_outcome_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic              cfg_index = CFG_REGION_START;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              mode = MODE_ALLOC;
  logic [ADDR_W-1:0] frame_address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] granted_address;
  logic [2:0]        status;
  logic [ADDR_W:0]   free_bytes;

  // Allocator state as the testbench sees it.
  logic [ADDR_W-1:0]            cur_start = '0;
  logic [ADDR_W-1:0]            cur_end = '0;
  longint unsigned              bump_pages = 0;
  logic [ADDR_W-PAGE_SHIFT-1:0] freed_frames [STACK_DEPTH];
  int                           freed_count = 0;

  frame_request_t    queued_requests[$];
  frame_outcome_t    frame_outcomes[$];
  logic [ADDR_W-1:0] handed_out[$];

  bit steady_flow = 1'b0;
  int send_gap = 0;
  int hold_cycles = 0;
  int idle_cycles = 0;
  int error_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int config_writes = 0;
  int status_seen [5];

  page_frame_allocator_unit #(
    .PAGE_BYTES(4096),
    .STACK_DEPTH(STACK_DEPTH),
    .ADDRESS_BITS(ADDR_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .frame_address(frame_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .granted_address(granted_address),
    .status(status),
    .free_bytes(free_bytes)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("ERROR at %0t: %s", $time, what);
    end
  endtask

  // Untouched region above the bump pointer plus the frames held on the stack.
  function automatic logic [ADDR_W:0] bytes_left();
    longint unsigned next_addr;
    longint unsigned untouched;
    longint unsigned total;
    if (cur_start == '0) return '0;
    next_addr = 64'(cur_start) + bump_pages * PAGE_BYTES;
    untouched = (64'(cur_end) > next_addr) ? 64'(cur_end) - next_addr : 64'd0;
    total = untouched + longint'(freed_count) * PAGE_BYTES;
    if (total > BYTES_MAX) total = BYTES_MAX;
    return total[ADDR_W:0];
  endfunction

  // Applies one accepted request to the state and queues the result it must give.
  task automatic serve_request(input logic req_mode, input logic [ADDR_W-1:0] req_addr);
    frame_outcome_t  res;
    longint unsigned next_addr;
    res.granted = '0;
    res.status = ST_OK;
    if (req_mode == MODE_ALLOC) begin
      if (cur_start == '0) begin
        res.status = ST_UNINIT;
      end else if (freed_count > 0) begin
        freed_count--;
        res.granted = {freed_frames[freed_count], {PAGE_SHIFT{1'b0}}};
      end else begin
        next_addr = 64'(cur_start) + bump_pages * PAGE_BYTES;
        if (next_addr + PAGE_BYTES > 64'(cur_end)) begin
          res.status = ST_OOM;
        end else begin
          res.granted = next_addr[ADDR_W-1:0];
          bump_pages++;
        end
      end
      if (res.status == ST_OK && handed_out.size() < 64) handed_out.push_back(res.granted);
    end else begin
      if (req_addr[PAGE_SHIFT-1:0] != '0) begin
        res.status = ST_MISALIGNED;
      end else if (freed_count >= STACK_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        freed_frames[freed_count] = req_addr[ADDR_W-1:PAGE_SHIFT];
        freed_count++;
      end
    end
    res.bytes = bytes_left();
    frame_outcomes.push_back(res);
  endtask

  function automatic logic [ADDR_W-1:0] random_address();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  // Keeps only a few requests queued, so frees can reuse recently granted frames.
  task automatic queue_request(input logic req_mode, input logic [ADDR_W-1:0] req_addr);
    frame_request_t req;
    while (queued_requests.size() >= 4) @(negedge clk);
    req.mode = req_mode;
    req.addr = req_addr;
    queued_requests.push_back(req);
  endtask

  // Waits until every request has been transferred and answered, then lets the
  // pipeline settle.
  task automatic drain();
    while (queued_requests.size() != 0 || in_valid || frame_outcomes.size() != 0) begin
      @(negedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  // Both region registers, written one after the other while the block is idle.
  task automatic write_regions(input logic [ADDR_W-1:0] start_val,
                               input logic [ADDR_W-1:0] end_val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_REGION_START;
    cfg_data <= start_val;
    @(posedge clk);
    cfg_index <= CFG_REGION_END;
    cfg_data <= end_val;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_start = start_val;
    cur_end = end_val;
    config_writes += 2;
  endtask

  // Mostly well-formed traffic: frees of granted or aligned frames, some noise.
  task automatic random_requests(input int count, input int free_pct);
    int                pick;
    logic [ADDR_W-1:0] addr;
    for (int i = 0; i < count; i++) begin
      addr = random_address();
      if ($urandom_range(99) < free_pct) begin
        pick = $urandom_range(9);
        if (pick < 4 && handed_out.size() > 0) begin
          addr = handed_out.pop_front();
        end else if (pick < 8) begin
          addr[PAGE_SHIFT-1:0] = '0;
        end
        queue_request(MODE_FREE, addr);
      end else begin
        queue_request(MODE_ALLOC, addr);
      end
    end
  endtask

  // Request driver: one item per transfer, with a random gap per item, or none when steady_flow is set.
  always @(posedge clk) begin
    frame_request_t req;
    if (rst) begin
      in_valid <= 1'b0;
      mode <= MODE_ALLOC;
      frame_address <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        serve_request(mode, frame_address);
        requests_sent++;
        send_gap = steady_flow ? 0 : $urandom_range(MAX_GAP);
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap == 0 && queued_requests.size() != 0) begin
          req = queued_requests.pop_front();
          in_valid <= 1'b1;
          mode <= req.mode;
          frame_address <= req.addr;
        end else begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // Result monitor: checks each transfer against the oldest outcome, then
  // stalls for a random number of cycles, or not at all when steady_flow is set.
  always @(posedge clk) begin
    frame_outcome_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (frame_outcomes.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding: granted %h status %0d",
                                    granted_address, status));
        end else begin
          want = frame_outcomes.pop_front();
          if (want.status < 5) status_seen[want.status]++;
          if (granted_address !== want.granted) begin
            report_mismatch($sformatf("granted_address %h, predicted %h",
                                      granted_address, want.granted));
          end
          if (status !== want.status) begin
            report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
          end
          if (free_bytes !== want.bytes) begin
            report_mismatch($sformatf("free_bytes %h, predicted %h", free_bytes, want.bytes));
          end
        end
        hold_cycles = steady_flow ? 0 : $urandom_range(MAX_GAP);
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL page_frame_allocator_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [ADDR_W-1:0] addr;
    longint unsigned   start64;
    longint unsigned   end64;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Not initialised: allocations are refused, aligned frees still go onto the stack.
    queue_request(MODE_ALLOC, '0);
    queue_request(MODE_FREE, '0);
    queue_request(MODE_FREE, '1);
    queue_request(MODE_FREE, 40'hFF_FFFF_F000);
    queue_request(MODE_ALLOC, '1);
    drain();

    // Three pages: the two stacked frames come back last in first out, then the
    // bump pointer runs to the end and reports out of memory.
    write_regions(40'h00_0000_1000, 40'h00_0000_4000);
    repeat (6) queue_request(MODE_ALLOC, random_address());
    queue_request(MODE_FREE, 40'h00_0000_0123);
    queue_request(MODE_FREE, 40'h00_0000_5000);
    queue_request(MODE_ALLOC, '0);
    drain();

    // Region end pulled below the bump pointer: the untouched part counts as zero.
    write_regions(40'h00_0000_1000, 40'h00_0000_1000);
    queue_request(MODE_ALLOC, '0);
    queue_request(MODE_FREE, 40'h00_0000_7000);
    queue_request(MODE_FREE, 40'h00_0000_0800);
    drain();

    // Top of the address space, with the bump address past the last byte.
    write_regions(40'hFF_FFFF_F000, '1);
    queue_request(MODE_ALLOC, '0);
    queue_request(MODE_ALLOC, '0);
    queue_request(MODE_FREE, 40'hFF_FFFF_F000);
    queue_request(MODE_FREE, 40'hFF_FFFF_FFFF);
    queue_request(MODE_ALLOC, '1);
    drain();

    // Random phases, each under a fresh region setting.
    for (int phase = 0; phase < 8; phase++) begin
      start64 = 64'(random_address());
      end64 = 64'(random_address());
      case (phase % 5)
        0: begin
          start64 = start64 & 64'h0000_0000_FFFF_F000;
          end64 = start64 + (bump_pages + $urandom_range(40)) * PAGE_BYTES;
        end
        1: begin
          start64 = ADDR_MAX + 1 - (bump_pages + 8) * PAGE_BYTES;
          end64 = ADDR_MAX;
        end
        2: end64 = ADDR_MAX;
        3: start64 = 0;
        default: start64 = start64 & ~(PAGE_BYTES - 1);
      endcase
      if (end64 > ADDR_MAX) end64 = ADDR_MAX;
      write_regions(start64[ADDR_W-1:0], end64[ADDR_W-1:0]);
      steady_flow = ($urandom_range(3) == 0);
      random_requests(16, (phase % 2 == 1) ? 70 : 25);
      drain();
    end

    // Fill the stack past its depth, then take a few frames back off the top.
    write_regions(40'h00_0010_0000, 40'h00_0010_8000);
    steady_flow = ($urandom_range(1) == 0);
    repeat (STACK_DEPTH + 4) begin
      addr = random_address();
      addr[PAGE_SHIFT-1:0] = '0;
      queue_request(MODE_FREE, addr);
    end
    repeat (8) queue_request(MODE_ALLOC, random_address());
    drain();

    repeat (10) @(posedge clk);
    if (frame_outcomes.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", frame_outcomes.size()));
    end
    $display("Ran %0d requests and checked %0d results across %0d register writes.",
             requests_sent, results_checked, config_writes);
    $display("Statuses: ok %0d, out of memory %0d, misaligned %0d, stack full %0d, uninit %0d.",
             status_seen[ST_OK], status_seen[ST_OOM], status_seen[ST_MISALIGNED],
             status_seen[ST_FULL], status_seen[ST_UNINIT]);
    if (error_count == 0) begin
      $display("PASS page_frame_allocator_unit");
    end else begin
      $display("FAIL page_frame_allocator_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire
